### design/scd_pkg.sv
`default_nettype none

package scd_pkg;

    // Input command codes.
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // Modifier scan codes with the break bit removed.
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_CTRL   = 7'h1D;
    localparam logic [6:0] CODE_ALT    = 7'h38;
    localparam logic [6:0] CODE_SCROLL = 7'h46;
    localparam logic [6:0] CODE_NUM    = 7'h45;

    localparam logic [15:0] KEY_END   = 16'hFFFF;
    localparam logic [7:0]  CHAR_MISS = 8'h20;
    localparam logic [7:0]  CHAR_NONE = 8'h00;
    localparam logic [7:0]  PRESS_CLR = 8'hFE;

    typedef struct packed {
        logic        command;
        logic [7:0]  scan_code;
        logic [6:0]  entry_index;
        logic [15:0] entry_key;
        logic [7:0]  entry_char;
    } item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] modifier_flags;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOOK,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic take;
        logic finish_mod;
        logic look_step;
        logic finish_lookup;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic item_valid;
        logic item_write;
        logic is_modifier;
        logic look_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

### design/scd_stream_if.sv
`default_nettype none

interface scd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/scd_ram.sv
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/scd_ctrl.sv
`default_nettype none

module scd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scd_pkg::dp_status_t status,
    output scd_pkg::ctrl_cmd_t      cmd
);

    import scd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.item_valid && !status.item_write)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_modifier)
                begin
                    cmd.finish_mod = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look_step = 1'b1;
                if (status.look_done)
                begin
                    cmd.finish_lookup = 1'b1;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/scd_datapath.sv
`default_nettype none

module scd_datapath #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    scd_stream_if.sink               item,
    scd_stream_if.source             result,
    input  wire scd_pkg::ctrl_cmd_t  cmd,
    output scd_pkg::dp_status_t      status
);

    import scd_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Break of a modifier: drop its flag, and the pressed bit only when the
    // other flags under the mask are all clear.
    function automatic logic [7:0] release_flag(
        input logic [7:0] m,
        input logic [7:0] others,
        input logic [7:0] keep_no_press,
        input logic [7:0] keep_press
    );
        if ((m & others) == 8'h00)
        begin
            return m & keep_no_press;
        end
        return m & keep_press;
    endfunction

    function automatic logic [7:0] mod_update(input logic [7:0] m, input logic [7:0] code);
        logic       brk;
        logic [7:0] r;
        brk = code[7];
        r   = m;
        if (code[6:0] == CODE_RSHIFT || code[6:0] == CODE_LSHIFT)
        begin
            r = brk ? release_flag(m, 8'h6E, 8'h7E, 8'h7F) : (m | 8'h81);
        end
        else if (code[6:0] == CODE_CTRL)
        begin
            r = brk ? release_flag(m, 8'hAE, 8'hBE, 8'hBF) : (m | 8'h41);
        end
        else if (code[6:0] == CODE_ALT)
        begin
            r = brk ? release_flag(m, 8'hCE, 8'hDE, 8'hDF) : (m | 8'h21);
        end
        else if (code[6:0] == CODE_SCROLL)
        begin
            r = brk ? release_flag(m, 8'hEE, 8'hEE, 8'hEF) : (m | 8'h11);
        end
        else if (code[6:0] == CODE_NUM)
        begin
            r = brk ? release_flag(m, 8'hF6, 8'hF6, 8'hF7) : (m | 8'h09);
        end
        return r;
    endfunction

    logic [7:0]       modifier_reg;
    logic [7:0]       modifier_next;
    logic [IDX_W-1:0] walk_idx_reg;
    logic [IDX_W-1:0] walk_idx_next;
    logic [7:0]       code_reg;
    logic [7:0]       res_char_reg;
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_flags_reg;

    logic             accept;
    logic             in_range;
    logic             key_we;
    logic             char_we;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      key_wdata;
    logic [IDX_W-1:0] raddr;
    logic [15:0]      key_rd;
    logic [7:0]       char_rd;
    logic [15:0]      search;
    logic             hit;

    assign accept   = item.valid && cmd.take;
    assign in_range = (32'(item.payload.entry_index) < TABLE_DEPTH);
    assign char_we  = accept && (item.payload.command == CMD_WRITE) && in_range;
    assign key_we   = cmd.clear_step || char_we;
    assign waddr    = cmd.clear_step ? walk_idx_reg : IDX_W'(item.payload.entry_index);
    assign key_wdata = cmd.clear_step ? KEY_END : item.payload.entry_key;

    // While walking, the address runs one slot ahead of the data being compared.
    assign raddr  = cmd.look_step ? (walk_idx_reg + IDX_W'(1)) : walk_idx_reg;
    assign search = {modifier_reg[7], 7'b0000000, code_reg};
    assign hit    = (key_rd == search);

    scd_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rd)
    );

    scd_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (waddr),
        .wdata (item.payload.entry_char),
        .raddr (raddr),
        .rdata (char_rd)
    );

    always_comb
    begin
        walk_idx_next = walk_idx_reg;
        if (cmd.clear_step || cmd.look_step)
        begin
            walk_idx_next = walk_idx_reg + IDX_W'(1);
        end
        else if (accept && (item.payload.command == CMD_DECODE))
        begin
            walk_idx_next = '0;
        end
    end

    always_comb
    begin
        modifier_next = modifier_reg;
        if (cmd.finish_mod)
        begin
            modifier_next = mod_update(modifier_reg, code_reg);
        end
        else if (cmd.finish_lookup && code_reg[7])
        begin
            modifier_next = modifier_reg & PRESS_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg  <= 8'h00;
            walk_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modifier_reg <= modifier_next;
            walk_idx_reg <= walk_idx_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.payload.command == CMD_DECODE))
        begin
            code_reg <= item.payload.scan_code;
        end
        if (cmd.finish_mod)
        begin
            res_char_reg <= CHAR_NONE;
        end
        else if (cmd.finish_lookup)
        begin
            res_char_reg <= hit ? char_rd : CHAR_MISS;
        end
        if (cmd.emit)
        begin
            out_char_reg  <= res_char_reg;
            out_flags_reg <= modifier_reg;
        end
    end

    assign item.ready                    = cmd.take;
    assign result.valid                  = out_valid_reg;
    assign result.payload.char_code      = out_char_reg;
    assign result.payload.modifier_flags = out_flags_reg;

    assign status.clear_last  = (walk_idx_reg == LAST_IDX);
    assign status.item_valid  = item.valid;
    assign status.item_write  = (item.payload.command == CMD_WRITE);
    assign status.is_modifier = (code_reg[6:0] == CODE_RSHIFT) || (code_reg[6:0] == CODE_LSHIFT)
                             || (code_reg[6:0] == CODE_CTRL) || (code_reg[6:0] == CODE_ALT)
                             || (code_reg[6:0] == CODE_SCROLL) || (code_reg[6:0] == CODE_NUM);
    assign status.look_done   = (key_rd == KEY_END) || hit || (walk_idx_reg == LAST_IDX);
    assign status.out_busy    = out_valid_reg && !result.ready;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !result.ready))
        else $error("pending result overwritten");

    a_decode_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.payload.command == CMD_DECODE)) |=> !item.ready)
        else $error("new item taken while a decode is in progress");

    a_make_presses: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_mod && !code_reg[7]) |=> modifier_reg[0])
        else $error("modifier make did not set the pressed bit");

    a_break_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_lookup && code_reg[7]) |=> !modifier_reg[0])
        else $error("table key break left the pressed bit set");
`endif

endmodule

`default_nettype wire

### design/scancode_to_char_decoder.sv
// Decode: a modifier code goes from the decode state straight to the emit state; a table
//   code first walks the key memory, 1 to TABLE_DEPTH slots, before its result is emitted.
// Flow: a new scan code is taken only once the last one has been emitted, and emit waits on a
//   busy output register; table writes are taken in the idle state. The key memory has one read port.
// Reset: asynchronous, active low; the modifier byte clears, then a clearing pass fills
//   every key slot with the terminator, during which no input is taken.
`default_nettype none

module scancode_to_char_decoder #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    scd_stream_if.sink   item,
    scd_stream_if.source result
);

    import scd_pkg::*;

    // The controller sequences the clearing pass, the classification of a
    // scan code, the table walk and the hand-off into the output register.
    // It sees the datapath only through the command and status structs.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    scd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the modifier byte, the key and character memories,
    // the walk counter and the output register. The output register lets the
    // next input transfer be taken while a finished result still waits.
    scd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
